// ===== src/pwga_pkg.sv =====
// ----------------------------------------------------------------------------
// pwga_pkg: shared widths, register codes and helpers
// Constants and functions used by the gather address pipeline and its checker.
// ----------------------------------------------------------------------------
package pwga_pkg;

  localparam int unsigned COORD_W   = 10;  // destination and source coordinate
  localparam int unsigned DIM_W     = 11;  // grid dimension register
  localparam int unsigned SHIFT_W   = 11;  // signed window shift register
  localparam int unsigned IDX_W     = 30;  // linear source index
  localparam int unsigned POS_W     = 14;  // signed pre-wrap position
  localparam int unsigned DXDY_W    = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;
  localparam int unsigned MAX_DIM   = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_X       = 3'd0,
    REG_DIM_Y       = 3'd1,
    REG_DIM_Z       = 3'd2,
    REG_SHIFT_X     = 3'd3,
    REG_SHIFT_Y     = 3'd4,
    REG_SHIFT_Z     = 3'd5,
    REG_DUAL_STRIDE = 3'd6
  } cfg_reg_e;

  // Clamp a dimension register into [1, MAX_DIM].
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== src/periodic_window_gather_address.sv =====
// Four register stages lie between input accept and result valid.
// Throughput: one item per cycle; stages advance whenever the next stage
// is empty or moving, so a stall on the output backs up without loss.
// Stages: pre-wrap position, range check and wrap, multiplies, index sum.
// Reset clears all stage valid bits and sets the registers to dims 1,
// shifts 0, stride one.
// ----------------------------------------------------------------------------
// periodic_window_gather_address
// Maps a destination window coordinate to a wrapped periodic source
// coordinate and its linear source index, one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module periodic_window_gather_address (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwga_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pwga_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pwga_pkg::COORD_W-1:0]    dst_x_i,
  input  logic [pwga_pkg::COORD_W-1:0]    dst_y_i,
  input  logic [pwga_pkg::COORD_W-1:0]    dst_z_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pwga_pkg::COORD_W-1:0]    src_x_o,
  output logic [pwga_pkg::COORD_W-1:0]    src_y_o,
  output logic [pwga_pkg::COORD_W-1:0]    src_z_o,
  output logic [pwga_pkg::IDX_W-1:0]      src_index_o,
  output logic                            out_of_range_o
);

  localparam int unsigned CW = pwga_pkg::COORD_W;
  localparam int unsigned DW = pwga_pkg::DIM_W;
  localparam int unsigned SW = pwga_pkg::SHIFT_W;
  localparam int unsigned PW = pwga_pkg::POS_W;
  localparam int unsigned IW = pwga_pkg::IDX_W;
  localparam int unsigned MW = pwga_pkg::DXDY_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic [SW-1:0] shift_x_q, shift_y_q, shift_z_q;
  logic          dual_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q   <= DW'(1);
      dim_y_q   <= DW'(1);
      dim_z_q   <= DW'(1);
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
      dual_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pwga_pkg::REG_DIM_X:       dim_x_q   <= cfg_data_i[DW-1:0];
        pwga_pkg::REG_DIM_Y:       dim_y_q   <= cfg_data_i[DW-1:0];
        pwga_pkg::REG_DIM_Z:       dim_z_q   <= cfg_data_i[DW-1:0];
        pwga_pkg::REG_SHIFT_X:     shift_x_q <= cfg_data_i[SW-1:0];
        pwga_pkg::REG_SHIFT_Y:     shift_y_q <= cfg_data_i[SW-1:0];
        pwga_pkg::REG_SHIFT_Z:     shift_z_q <= cfg_data_i[SW-1:0];
        pwga_pkg::REG_DUAL_STRIDE: dual_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dx, dy, dz;
  assign dx = pwga_pkg::eff_dim(dim_x_q);
  assign dy = pwga_pkg::eff_dim(dim_y_q);
  assign dz = pwga_pkg::eff_dim(dim_z_q);

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pre-wrap position stride*dst + shift, and dx*dy
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] px_d, py_d, pz_d;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic [MW-1:0]        dxdy_d, dxdy_q, dxdy2_q;

  function automatic logic signed [PW-1:0] pre_wrap(input logic [CW-1:0] c,
                                                    input logic [SW-1:0] s,
                                                    input logic          dual);
    logic        [CW:0]   sc;
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    sc = dual ? {c, 1'b0} : {1'b0, c};
    a  = {{(PW-CW-1){1'b0}}, sc};
    b  = {{(PW-SW){s[SW-1]}}, s};
    return a + b;
  endfunction

  assign px_d   = pre_wrap(dst_x_i, shift_x_q, dual_q);
  assign py_d   = pre_wrap(dst_y_i, shift_y_q, dual_q);
  assign pz_d   = pre_wrap(dst_z_i, shift_z_q, dual_q);
  assign dxdy_d = dx * dy;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      dxdy_q <= dxdy_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: range check and wrap into [0, dim)
  // --------------------------------------------------------------------------
  function automatic logic in_range(input logic signed [PW-1:0] p,
                                    input logic [DW-1:0]        d);
    logic signed [PW-1:0] ds;
    ds = {{(PW-DW){1'b0}}, d};
    return (p >= -ds) && (p < (ds <<< 1));
  endfunction

  function automatic logic [CW-1:0] wrap(input logic signed [PW-1:0] p,
                                         input logic [DW-1:0]        d);
    logic signed [PW-1:0] ds;
    logic signed [PW-1:0] r;
    ds = {{(PW-DW){1'b0}}, d};
    if (p < 0) begin
      r = p + ds;
    end else if (p >= ds) begin
      r = p - ds;
    end else begin
      r = p;
    end
    return r[CW-1:0];
  endfunction

  logic          oor_d;
  logic [CW-1:0] x2_q, y2_q, z2_q;
  logic          oor2_q;

  assign oor_d = !(in_range(px_q, dx) && in_range(py_q, dy) && in_range(pz_q, dz));

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      // zero the coordinates of an out-of-range item so the index sums to 0
      x2_q    <= oor_d ? '0 : wrap(px_q, dx);
      y2_q    <= oor_d ? '0 : wrap(py_q, dy);
      z2_q    <= oor_d ? '0 : wrap(pz_q, dz);
      oor2_q  <= oor_d;
      dxdy2_q <= dxdy_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: y*dx and z*dx*dy
  // --------------------------------------------------------------------------
  logic [CW+DW-1:0] ydx_d, ydx_q;
  logic [CW+MW-1:0] zdd_d;
  logic [IW-1:0]    zdd_q;
  logic [CW-1:0]    x3_q, y3_q, z3_q;
  logic             oor3_q;

  assign ydx_d = y2_q * dx;
  assign zdd_d = z2_q * dxdy2_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      ydx_q  <= ydx_d;
      zdd_q  <= zdd_d[IW-1:0];
      x3_q   <= x2_q;
      y3_q   <= y2_q;
      z3_q   <= z2_q;
      oor3_q <= oor2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: index sum, output register
  // --------------------------------------------------------------------------
  logic [IW-1:0] idx_d;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] x4_q, y4_q, z4_q;
  logic          oor4_q;

  assign idx_d = IW'(x3_q) + IW'(ydx_q) + zdd_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      idx_q  <= idx_d;
      x4_q   <= x3_q;
      y4_q   <= y3_q;
      z4_q   <= z3_q;
      oor4_q <= oor3_q;
    end
  end

  assign out_valid_o    = v4_q;
  assign src_x_o        = x4_q;
  assign src_y_o        = y4_q;
  assign src_z_o        = z4_q;
  assign src_index_o    = idx_q;
  assign out_of_range_o = oor4_q;

endmodule

// ===== src/pwga_checker.sv =====
// ----------------------------------------------------------------------------
// pwga_checker
// Port-level checks on the gather address pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pwga_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [pwga_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [pwga_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [pwga_pkg::COORD_W-1:0]    dst_x_i,
  input logic [pwga_pkg::COORD_W-1:0]    dst_y_i,
  input logic [pwga_pkg::COORD_W-1:0]    dst_z_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [pwga_pkg::COORD_W-1:0]    src_x_o,
  input logic [pwga_pkg::COORD_W-1:0]    src_y_o,
  input logic [pwga_pkg::COORD_W-1:0]    src_z_o,
  input logic [pwga_pkg::IDX_W-1:0]      src_index_o,
  input logic                            out_of_range_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(src_index_o)
      && $stable(out_of_range_o))
    else $error("stalled result dropped or changed");

  // stall the input only when the whole pipeline is full and blocked
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can move");

  // out-of-range items carry zero fields
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> src_index_o == '0 && src_x_o == '0
      && src_y_o == '0 && src_z_o == '0)
    else $error("out-of-range result has nonzero fields");

  // an accepted item reaches the output if the output does not stall on the way
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i [*3] |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind periodic_window_gather_address pwga_checker u_pwga_checker (.*);
